>>> hdl/dqpa_pkg.sv
package dqpa_pkg;

   // field widths and fixed-point format
   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int OUT_W   = 48;

   // magnitude of a product of two data words, and of the sums of two such
   localparam int MAG_W   = 2 * DATA_W;
   // magnitude of weight times coefficient (unsigned times signed)
   localparam int NUM_W   = 2 * DATA_W - 1;
   // dividend width: numerator shifted up by the fraction bits
   localparam int QUO_W   = NUM_W + FRAC_W;
   // full product of scale and one sum of products
   localparam int MPROD_W = QUO_W + MAG_W;
   // right shift that brings the product back to the output format
   localparam int SHIFT_W = 2 * FRAC_W;
   // limb width of the split multiplier
   localparam int LIMB_W  = 32;

   localparam logic [DATA_W-1:0] COEF_RESET =
      {{(DATA_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

   // what rides along with the divider
   typedef struct packed {
      logic [MAG_W-1:0] sxx;
      logic [MAG_W-1:0] sxy;
      logic [MAG_W-1:0] syy;
      logic             scale_neg;
      logic             xy_neg;
      logic             det_zero;
   } side_type;

   typedef struct packed {
      logic [QUO_W-1:0] dividend;
      logic [MAG_W-1:0] divisor;
      side_type         side;
   } div_in_type;

   typedef struct packed {
      logic [QUO_W-1:0] quot;
      side_type         side;
   } div_out_type;

   // one operator entry after rounding, before clipping
   typedef struct packed {
      logic             over;
      logic [OUT_W-1:0] mag;
      logic             neg;
   } ent_type;

   typedef struct packed {
      logic [OUT_W-1:0] op_xx;
      logic [OUT_W-1:0] op_xy;
      logic [OUT_W-1:0] op_yy;
      logic             det_zero;
      logic             saturated;
   } rsp_type;

endpackage

>>> hdl/dqpa_front.sv
module dqpa_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [dqpa_pkg::DATA_W-1:0] jac_11,
   input  logic signed [dqpa_pkg::DATA_W-1:0] jac_12,
   input  logic signed [dqpa_pkg::DATA_W-1:0] jac_21,
   input  logic signed [dqpa_pkg::DATA_W-1:0] jac_22,
   input  logic        [dqpa_pkg::DATA_W-1:0] quad_weight,
   input  logic signed [dqpa_pkg::DATA_W-1:0] coefficient,
   output logic                               out_valid,
   output dqpa_pkg::div_in_type               out_word
);
   import dqpa_pkg::*;

   logic va_ff, vb_ff, vc_ff;

   logic signed [MAG_W-1:0] pad_ff, pcb_ff, pcc_ff, pdd_ff;
   logic signed [MAG_W-1:0] pca_ff, pdb_ff, paa_ff, pbb_ff;
   logic signed [MAG_W:0]   num_ff;

   logic signed [MAG_W:0]   det_ff, sxy_ff, numb_ff;
   logic        [MAG_W-1:0] sxx_ff, syy_ff;

   logic [MAG_W:0] det_abs, sxy_abs, num_abs;
   div_in_type     out_in, out_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // stage A: the Jacobian products needed below, and weight times coefficient
   always_ff @(posedge clock) begin
      if (advance) begin
         pad_ff <= jac_11 * jac_22;
         pcb_ff <= jac_21 * jac_12;
         pcc_ff <= jac_21 * jac_21;
         pdd_ff <= jac_22 * jac_22;
         pca_ff <= jac_21 * jac_11;
         pdb_ff <= jac_22 * jac_12;
         paa_ff <= jac_11 * jac_11;
         pbb_ff <= jac_12 * jac_12;
         num_ff <= $signed({1'b0, quad_weight}) * coefficient;
      end
   end

   // stage B: determinant and the three sums of products
   always_ff @(posedge clock) begin
      if (advance) begin
         det_ff  <= {pad_ff[MAG_W-1], pad_ff} - {pcb_ff[MAG_W-1], pcb_ff};
         sxy_ff  <= {pca_ff[MAG_W-1], pca_ff} + {pdb_ff[MAG_W-1], pdb_ff};
         sxx_ff  <= pcc_ff + pdd_ff;
         syy_ff  <= paa_ff + pbb_ff;
         numb_ff <= num_ff;
      end
   end

   // stage C: split into sign and magnitude for the divider
   assign det_abs = det_ff[MAG_W]  ? (~det_ff + 1'b1)  : det_ff;
   assign sxy_abs = sxy_ff[MAG_W]  ? (~sxy_ff + 1'b1)  : sxy_ff;
   assign num_abs = numb_ff[MAG_W] ? (~numb_ff + 1'b1) : numb_ff;

   always_comb begin
      out_in.dividend       = {num_abs[NUM_W-1:0], {FRAC_W{1'b0}}};
      out_in.divisor        = det_abs[MAG_W-1:0];
      out_in.side.sxx       = sxx_ff;
      out_in.side.syy       = syy_ff;
      out_in.side.sxy       = sxy_abs[MAG_W-1:0];
      out_in.side.scale_neg = numb_ff[MAG_W] ^ det_ff[MAG_W];
      out_in.side.xy_neg    = ~(numb_ff[MAG_W] ^ det_ff[MAG_W] ^ sxy_ff[MAG_W]);
      out_in.side.det_zero  = (det_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_word  = out_ff;

endmodule

>>> hdl/dqpa_div.sv
module dqpa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  dqpa_pkg::div_in_type  in_word,
   output logic                  out_valid,
   output dqpa_pkg::div_out_type out_word
);
   import dqpa_pkg::*;

   // one quotient bit per stage, restoring division
   logic             vld_ff  [QUO_W];
   logic [QUO_W-1:0] acc_ff  [QUO_W];
   logic [MAG_W-1:0] rem_ff  [QUO_W];
   logic [MAG_W-1:0] den_ff  [QUO_W];
   side_type         side_ff [QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_step
         logic             vld_prev;
         logic [QUO_W-1:0] acc_prev;
         logic [MAG_W-1:0] rem_prev;
         logic [MAG_W-1:0] den_prev;
         side_type         side_prev;
         logic [MAG_W:0]   trial;
         logic [MAG_W:0]   diff;
         logic             ge;
         logic [QUO_W-1:0] acc_in;
         logic [MAG_W-1:0] rem_in;

         if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign acc_prev  = in_word.dividend;
            assign rem_prev  = '0;
            assign den_prev  = in_word.divisor;
            assign side_prev = in_word.side;
         end else begin : g_next
            assign vld_prev  = vld_ff[k-1];
            assign acc_prev  = acc_ff[k-1];
            assign rem_prev  = rem_ff[k-1];
            assign den_prev  = den_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         // shift in the next dividend bit, subtract when it fits
         assign trial  = {rem_prev, acc_prev[QUO_W-1]};
         assign diff   = trial - {1'b0, den_prev};
         assign ge     = (trial >= {1'b0, den_prev});
         assign rem_in = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
         assign acc_in = {acc_prev[QUO_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (advance) begin
               vld_ff[k] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               acc_ff[k]  <= acc_in;
               rem_ff[k]  <= rem_in;
               den_ff[k]  <= den_prev;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign out_valid     = vld_ff[QUO_W-1];
   assign out_word.quot = acc_ff[QUO_W-1];
   assign out_word.side = side_ff[QUO_W-1];

   // remainder left by a finished division stays below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QUO_W-1] && !side_ff[QUO_W-1].det_zero)
         |-> (rem_ff[QUO_W-1] < den_ff[QUO_W-1]))
      else $error("division remainder not below divisor");

endmodule

>>> hdl/dqpa_entry.sv
module dqpa_entry (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [dqpa_pkg::QUO_W-1:0]   scale,
   input  logic [dqpa_pkg::MAG_W-1:0]   term,
   input  logic                         neg,
   output dqpa_pkg::ent_type            out_word
);
   import dqpa_pkg::*;

   localparam int TOP_W = QUO_W - 2 * LIMB_W;
   localparam int Q_W   = MPROD_W - SHIFT_W;

   logic [LIMB_W-1:0] s0, s1, s2, t0, t1;

   logic [2*LIMB_W-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff, pp20_ff, pp21_ff;
   logic                n1_ff, n2_ff, n3_ff, n4_ff;
   logic [2*LIMB_W-1:0] q00_ff, q21_ff;
   logic [2*LIMB_W:0]   c32_ff, c64_ff;
   logic [3*LIMB_W:0]   lo_ff, hi_ff;
   logic [MPROD_W-1:0]  m_ff;
   logic [Q_W:0]        q_in;
   logic                inc;
   ent_type             ent_ff;

   assign s0 = scale[LIMB_W-1:0];
   assign s1 = scale[2*LIMB_W-1:LIMB_W];
   assign s2 = {{(LIMB_W-TOP_W){1'b0}}, scale[QUO_W-1:2*LIMB_W]};
   assign t0 = term[LIMB_W-1:0];
   assign t1 = term[2*LIMB_W-1:LIMB_W];

   // stage 1: limb partial products
   always_ff @(posedge clock) begin
      if (advance) begin
         pp00_ff <= s0 * t0;
         pp01_ff <= s0 * t1;
         pp10_ff <= s1 * t0;
         pp11_ff <= s1 * t1;
         pp20_ff <= s2 * t0;
         pp21_ff <= s2 * t1;
         n1_ff   <= neg;
      end
   end

   // stage 2: add partial products of equal weight
   always_ff @(posedge clock) begin
      if (advance) begin
         c32_ff <= {1'b0, pp01_ff} + {1'b0, pp10_ff};
         c64_ff <= {1'b0, pp11_ff} + {1'b0, pp20_ff};
         q00_ff <= pp00_ff;
         q21_ff <= pp21_ff;
         n2_ff  <= n1_ff;
      end
   end

   // stage 3: low and high halves
   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff <= {{(LIMB_W+1){1'b0}}, q00_ff} + {c32_ff, {LIMB_W{1'b0}}};
         hi_ff <= {{LIMB_W{1'b0}}, c64_ff} + {1'b0, q21_ff, {LIMB_W{1'b0}}};
         n3_ff <= n2_ff;
      end
   end

   // stage 4: full product
   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff  <= MPROD_W'({hi_ff, {(2*LIMB_W){1'b0}}} + lo_ff);
         n4_ff <= n3_ff;
      end
   end

   // stage 5: drop the fraction, round negatives toward minus infinity
   assign inc  = n4_ff && (m_ff[SHIFT_W-1:0] != '0);
   assign q_in = {1'b0, m_ff[MPROD_W-1:SHIFT_W]} + {{Q_W{1'b0}}, inc};

   always_ff @(posedge clock) begin
      if (advance) begin
         ent_ff.over <= (q_in[Q_W:OUT_W] != '0);
         ent_ff.mag  <= q_in[OUT_W-1:0];
         ent_ff.neg  <= n4_ff;
      end
   end

   assign out_word = ent_ff;

endmodule

>>> hdl/dqpa_back.sv
module dqpa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  dqpa_pkg::div_out_type in_word,
   output logic                  out_valid,
   output dqpa_pkg::rsp_type     out_word
);
   import dqpa_pkg::*;

   localparam int ENT_LAT = 5;

   localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic    vld_ff [ENT_LAT];
   logic    dz_ff  [ENT_LAT];
   ent_type e_xx, e_xy, e_yy;
   logic [OUT_W:0] f_xx, f_xy, f_yy;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_vld_ff;

   // clip to the 48-bit range and apply the sign; top bit flags a clip
   function automatic logic [OUT_W:0] finish(input ent_type e);
      logic             sat;
      logic [OUT_W-1:0] lim;
      logic [OUT_W-1:0] mag;
      sat = e.neg ? (e.over || (e.mag[OUT_W-1] && (e.mag[OUT_W-2:0] != '0)))
                  : (e.over || e.mag[OUT_W-1]);
      lim = e.neg ? NEG_MIN : POS_MAX;
      mag = sat ? lim : e.mag;
      return {sat, e.neg ? (~mag + 1'b1) : mag};
   endfunction

   dqpa_entry u_xx (
      .clock    (clock),
      .advance  (advance),
      .scale    (in_word.quot),
      .term     (in_word.side.sxx),
      .neg      (in_word.side.scale_neg),
      .out_word (e_xx)
   );

   dqpa_entry u_xy (
      .clock    (clock),
      .advance  (advance),
      .scale    (in_word.quot),
      .term     (in_word.side.sxy),
      .neg      (in_word.side.xy_neg),
      .out_word (e_xy)
   );

   dqpa_entry u_yy (
      .clock    (clock),
      .advance  (advance),
      .scale    (in_word.quot),
      .term     (in_word.side.syy),
      .neg      (in_word.side.scale_neg),
      .out_word (e_yy)
   );

   // carry valid and the zero-determinant flag beside the entry pipes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENT_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < ENT_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_vld_ff <= vld_ff[ENT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dz_ff[0] <= in_word.side.det_zero;
         for (int i = 1; i < ENT_LAT; i++) begin
            dz_ff[i] <= dz_ff[i-1];
         end
      end
   end

   // final stage: clip, sign, force zeros on a zero determinant
   assign f_xx = finish(e_xx);
   assign f_xy = finish(e_xy);
   assign f_yy = finish(e_yy);

   always_comb begin
      if (dz_ff[ENT_LAT-1]) begin
         rsp_in.op_xx     = '0;
         rsp_in.op_xy     = '0;
         rsp_in.op_yy     = '0;
         rsp_in.det_zero  = 1'b1;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.op_xx     = f_xx[OUT_W-1:0];
         rsp_in.op_xy     = f_xy[OUT_W-1:0];
         rsp_in.op_yy     = f_yy[OUT_W-1:0];
         rsp_in.det_zero  = 1'b0;
         rsp_in.saturated = f_xx[OUT_W] | f_xy[OUT_W] | f_yy[OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_vld_ff;
   assign out_word  = rsp_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.det_zero)
         |-> (rsp_ff.op_xx == '0 && rsp_ff.op_xy == '0 && rsp_ff.op_yy == '0
              && !rsp_ff.saturated))
      else $error("zero determinant word carries nonzero entries");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.saturated)
         |-> (rsp_ff.op_xx == POS_MAX || rsp_ff.op_xx == NEG_MIN
              || rsp_ff.op_xy == POS_MAX || rsp_ff.op_xy == NEG_MIN
              || rsp_ff.op_yy == POS_MAX || rsp_ff.op_yy == NEG_MIN))
      else $error("saturated word has no entry at a bound");

endmodule

>>> hdl/diffusion_quad_point_assemble_2d_top.sv
// channel  direction  ports                                   handshake
// req      in         jac_11/12/21/22, quad_weight            req_valid/req_ready
// rsp      out        op_xx, op_xy, op_yy, det_zero, saturated rsp_valid/rsp_ready
// csr      in         coefficient                             csr_valid/csr_ready
//
// One point enters per cycle while rsp does not stall; the pipeline has 3 front stages, 79
// divider stages (one quotient bit each), 6 multiply and clip stages.
// Synchronous active-high reset clears all valid bits; coefficient resets to 1.0.
// A stall on rsp freezes the whole pipeline together; req_ready drops with it.
// csr is always ready and must be written only while the pipe is empty.
module diffusion_quad_point_assemble_2d_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [dqpa_pkg::DATA_W-1:0] req_jac_11,
   input  logic signed [dqpa_pkg::DATA_W-1:0] req_jac_12,
   input  logic signed [dqpa_pkg::DATA_W-1:0] req_jac_21,
   input  logic signed [dqpa_pkg::DATA_W-1:0] req_jac_22,
   input  logic        [dqpa_pkg::DATA_W-1:0] req_quad_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dqpa_pkg::OUT_W-1:0]  rsp_op_xx,
   output logic signed [dqpa_pkg::OUT_W-1:0]  rsp_op_xy,
   output logic signed [dqpa_pkg::OUT_W-1:0]  rsp_op_yy,
   output logic                               rsp_det_zero,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic signed [dqpa_pkg::DATA_W-1:0] csr_coefficient
);
   import dqpa_pkg::*;

   logic               advance;
   logic [DATA_W-1:0]  coef_ff;
   logic               fr_valid, dv_valid;
   div_in_type         fr_word;
   div_out_type        dv_word;
   rsp_type            rsp_word;

   // advance everything whenever the output word is free or taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // hold the coefficient register
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_valid) begin
         coef_ff <= csr_coefficient;
      end
   end

   dqpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .jac_11      (req_jac_11),
      .jac_12      (req_jac_12),
      .jac_21      (req_jac_21),
      .jac_22      (req_jac_22),
      .quad_weight (req_quad_weight),
      .coefficient ($signed(coef_ff)),
      .out_valid   (fr_valid),
      .out_word    (fr_word)
   );

   dqpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_word   (fr_word),
      .out_valid (dv_valid),
      .out_word  (dv_word)
   );

   dqpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dv_valid),
      .in_word   (dv_word),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   assign rsp_op_xx     = $signed(rsp_word.op_xx);
   assign rsp_op_xy     = $signed(rsp_word.op_xy);
   assign rsp_op_yy     = $signed(rsp_word.op_yy);
   assign rsp_det_zero  = rsp_word.det_zero;
   assign rsp_saturated = rsp_word.saturated;

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

>>> verif/diffusion_quad_point_assemble_2d_top_tb.sv
`timescale 1ns / 1ps

module diffusion_quad_point_assemble_2d_top_tb;
   import dqpa_pkg::*;

   localparam int PIPE_LAT = 88;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [OUT_W-1:0] op_xx;
      logic [OUT_W-1:0] op_xy;
      logic [OUT_W-1:0] op_yy;
      logic             det_zero;
      logic             saturated;
   } entry_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [DATA_W-1:0] req_jac_11 = '0, req_jac_12 = '0, req_jac_21 = '0, req_jac_22 = '0;
   logic [DATA_W-1:0] req_quad_weight = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_op_xx, rsp_op_xy, rsp_op_yy;
   logic rsp_det_zero, rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic signed [DATA_W-1:0] csr_coefficient = '0;

   diffusion_quad_point_assemble_2d_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_jac_11(req_jac_11), .req_jac_12(req_jac_12),
      .req_jac_21(req_jac_21), .req_jac_22(req_jac_22),
      .req_quad_weight(req_quad_weight),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_op_xx(rsp_op_xx), .rsp_op_xy(rsp_op_xy), .rsp_op_yy(rsp_op_yy),
      .rsp_det_zero(rsp_det_zero), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_coefficient(csr_coefficient)
   );

   logic signed [DATA_W-1:0] coef_shadow = COEF_RESET;
   entry_set_type expected_entries[$];
   int errors = 0;
   int points_sent = 0;
   int entries_checked = 0;
   int dz_seen = 0;
   int sat_seen = 0;
   int idle_pct = 26;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Clip one entry: floor shift by 2*FRAC, then clamp to the 48-bit range.
   function automatic logic [OUT_W-1:0] clip_entry(input logic signed [255:0] prod,
                                                   inout logic sat);
      logic signed [255:0] q;
      logic signed [255:0] hi, lo;
      hi = (256'sd1 <<< (OUT_W - 1)) - 1;
      lo = -(256'sd1 <<< (OUT_W - 1));
      q = prod >>> (2 * FRAC_W);
      if (q > hi) begin
         q = hi;
         sat = 1'b1;
      end else if (q < lo) begin
         q = lo;
         sat = 1'b1;
      end
      return q[OUT_W-1:0];
   endfunction

   // Work out the operator entries of one quadrature point.
   function automatic entry_set_type operator_entries(input logic signed [DATA_W-1:0] a11,
         input logic signed [DATA_W-1:0] a12, input logic signed [DATA_W-1:0] a21,
         input logic signed [DATA_W-1:0] a22, input logic [DATA_W-1:0] wt,
         input logic signed [DATA_W-1:0] coef);
      logic signed [255:0] j11, j12, j21, j22, num, det, scale, nmag, dmag, qmag;
      logic signed [255:0] sxx, sxy, syy;
      logic sat;
      entry_set_type r;
      j11 = a11; j12 = a12; j21 = a21; j22 = a22;
      num = $signed({224'd0, wt}) * $signed(256'(coef));
      det = j11 * j22 - j21 * j12;
      r = '0;
      sat = 1'b0;
      if (det == 0) begin
         r.det_zero = 1'b1;
         return r;
      end
      // truncate toward zero on magnitudes
      nmag = (num < 0) ? -num : num;
      dmag = (det < 0) ? -det : det;
      qmag = (nmag <<< FRAC_W) / dmag;
      scale = ((num < 0) != (det < 0)) ? -qmag : qmag;
      sxx = j21 * j21 + j22 * j22;
      sxy = j21 * j11 + j22 * j12;
      syy = j11 * j11 + j12 * j12;
      r.op_xx = clip_entry(scale * sxx, sat);
      r.op_xy = clip_entry(-(scale * sxy), sat);
      r.op_yy = clip_entry(scale * syy, sat);
      r.saturated = sat;
      return r;
   endfunction

   // Send one point; predict at acceptance. Valid drops only while idling.
   task automatic send_point(input logic [DATA_W-1:0] a11, input logic [DATA_W-1:0] a12,
                             input logic [DATA_W-1:0] a21, input logic [DATA_W-1:0] a22,
                             input logic [DATA_W-1:0] wt);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_jac_11 <= a11;
      req_jac_12 <= a12;
      req_jac_21 <= a21;
      req_jac_22 <= a22;
      req_quad_weight <= wt;
      do @(posedge clock); while (!req_ready);
      expected_entries.push_back(operator_entries(a11, a12, a21, a22, wt, coef_shadow));
      points_sent++;
   endtask

   // Drain the pipe before touching the coefficient.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_coefficient(input logic [DATA_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_coefficient <= value;
      do @(posedge clock); while (!csr_ready);
      coef_shadow = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         1: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
         2: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
         3: return 32'($signed($urandom_range(8 << FRAC_W)) - (4 << FRAC_W));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_reset_coefficient();
      send_point(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h0002_0000, 32'h0000_8000, 32'hffff_c000, 32'h0001_8000, 32'h0000_8000);
   endtask

   task automatic test_directed_extremes();
      // zero determinant: all zero and a singular matrix
      send_point(0, 0, 0, 0, 32'h0001_0000);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000, 32'hffff_ffff);
      // field extremes
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_point(32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff);
      send_point(1, 0, 0, 1, 32'hffff_ffff);
      send_point(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 1);
      send_point(32'h8000_0000, 1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      // negative determinant
      send_point(0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000);
      send_point(32'hffff_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000);
   endtask

   task automatic test_coefficient_sweep();
      logic [DATA_W-1:0] coefs[5];
      coefs = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'hfffe_0000};
      foreach (coefs[i]) begin
         write_coefficient(coefs[i]);
         send_point(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000);
         send_point(1, 0, 0, 1, 32'hffff_ffff);
         send_point(32'h8000_0000, 1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      end
   endtask

   task automatic test_random_points(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) write_coefficient($urandom_range(1) ? rand_word() : $urandom);
         // stretch with no idling on either side
         idle_pct = (i >= 400 && i < 550) ? 0 : 26;
         send_point(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      end
      idle_pct = 26;
   endtask

   // Check each result word against the oldest prediction.
   always @(posedge clock) begin
      entry_set_type got, want;
      if (!reset) begin
         rsp_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_op_xx, rsp_op_xy, rsp_op_yy, rsp_det_zero, rsp_saturated};
            if (expected_entries.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               errors++;
            end else begin
               want = expected_entries.pop_front();
               entries_checked++;
               if (want.det_zero) dz_seen++;
               if (want.saturated) sat_seen++;
               if (got.op_xx !== want.op_xx)
                  $display("%0t: op_xx expected %h actual %h", $time, want.op_xx, got.op_xx);
               if (got.op_xy !== want.op_xy)
                  $display("%0t: op_xy expected %h actual %h", $time, want.op_xy, got.op_xy);
               if (got.op_yy !== want.op_yy)
                  $display("%0t: op_yy expected %h actual %h", $time, want.op_yy, got.op_yy);
               if (got.det_zero !== want.det_zero)
                  $display("%0t: det_zero expected %b actual %b", $time, want.det_zero,
                           got.det_zero);
               if (got.saturated !== want.saturated)
                  $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                           got.saturated);
               if (got !== want) errors++;
            end
         end
      end
   end

   // Watchdog on handshake inactivity.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("** diffusion_quad_point_assemble_2d_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_coefficient();
      test_directed_extremes();
      // hold off until everything is back
      wait_drained();
      test_coefficient_sweep();
      test_random_points(1030);
      wait_drained();
      if (expected_entries.size() != 0) errors++;
      $display("Covered %0d points, %0d results checked, %0d zero-det, %0d clipped.",
               points_sent, entries_checked, dz_seen, sat_seen);
      if (errors == 0) begin
         $display("** diffusion_quad_point_assemble_2d_top: PASSED **");
      end else begin
         $display("** diffusion_quad_point_assemble_2d_top: FAILED **");
      end
      $finish;
   end

endmodule
